FILE: sv/hsl_to_rgb_converter_top_defines.svh
// hsl_to_rgb_converter_top_defines.svh: assertion macros for the hsl to rgb converter
// depends on nothing; included by files that carry concurrent assertions
// macros expect a clock named clk and an active-low reset named rst_n in scope
`ifndef HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// plain property checked on every rising clock edge outside reset
`define HSL2RGB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication with an antecedent and a consequent written apart
`define HSL2RGB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define HSL2RGB_ASSERT(label, prop, msg)
`define HSL2RGB_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

FILE: sv/hsl2rgb_pkg.sv
// hsl2rgb_pkg.sv: types and fixed-point constants shared by the hsl to rgb converter
// depends on nothing; used by hsl2rgb_levels, hsl2rgb_ramp and the top level
package hsl2rgb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_W    = 8;
    localparam int LVL_W      = FRAC_BITS + 1;
    localparam int PIPE_DEPTH = 4;

    localparam int unsigned ONE_Q = 1 << FRAC_BITS;

    localparam logic [FRAC_BITS-1:0] HALF_Q       = FRAC_BITS'(ONE_Q / 2);
    localparam logic [FRAC_BITS-1:0] SIXTH_Q      = FRAC_BITS'(ONE_Q / 6);
    localparam logic [FRAC_BITS-1:0] THIRD_Q      = FRAC_BITS'(ONE_Q / 3);
    localparam logic [FRAC_BITS-1:0] TWO_THIRDS_Q = FRAC_BITS'((2 * ONE_Q) / 3);

    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [LVL_W-1:0]     lvl_t;

    // the two ramp levels and their difference
    typedef struct packed {
        lvl_t m1;
        lvl_t m2;
        lvl_t span;
    } levels_t;

    // hue ramp segment codes
    typedef logic [1:0] seg_t;
    localparam seg_t SEG_RISE = 2'd0;
    localparam seg_t SEG_HIGH = 2'd1;
    localparam seg_t SEG_FALL = 2'd2;
    localparam seg_t SEG_LOW  = 2'd3;

endpackage

FILE: sv/hsl2rgb_levels.sv
// hsl2rgb_levels.sv: two-stage pipeline that forms the ramp levels m1, m2 and their span
// depends on hsl2rgb_pkg
module hsl2rgb_levels
(
    input  logic                       clk,
    input  hsl2rgb_pkg::frac_t         saturation,
    input  hsl2rgb_pkg::frac_t         lightness,
    output hsl2rgb_pkg::levels_t       levels
);

    localparam int F      = hsl2rgb_pkg::FRAC_BITS;
    localparam int PROD_W = 2 * F;

    // stage 1: lightness times saturation
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    hsl2rgb_pkg::frac_t  l_reg;
    hsl2rgb_pkg::frac_t  s_reg;

    // stage 2: levels
    hsl2rgb_pkg::levels_t levels_reg;
    hsl2rgb_pkg::levels_t levels_next;

    hsl2rgb_pkg::frac_t  ls;
    hsl2rgb_pkg::lvl_t   twice_l;
    hsl2rgb_pkg::lvl_t   m2;
    hsl2rgb_pkg::lvl_t   m1;

    assign prod_next = PROD_W'(saturation) * PROD_W'(lightness);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        l_reg    <= lightness;
        s_reg    <= saturation;
    end

    always_comb
    begin
        ls      = prod_reg[PROD_W-1:F];
        twice_l = {l_reg, 1'b0};
        if (l_reg <= hsl2rgb_pkg::HALF_Q)
        begin
            m2 = {1'b0, l_reg} + {1'b0, ls};
        end
        else
        begin
            // ls never exceeds saturation, so no borrow
            m2 = {1'b0, l_reg} + {1'b0, s_reg} - {1'b0, ls};
        end
        m1 = (twice_l >= m2) ? (twice_l - m2) : '0;
        levels_next.m1   = m1;
        levels_next.m2   = m2;
        levels_next.span = m2 - m1;
    end

    always_ff @(posedge clk)
    begin
        levels_reg <= levels_next;
    end

    assign levels = levels_reg;

endmodule

FILE: sv/hsl2rgb_ramp.sv
// hsl2rgb_ramp.sv: three-stage hue ramp for one color channel with output saturation
// depends on hsl2rgb_pkg; levels arrive in the cycle after the channel hue
module hsl2rgb_ramp
(
    input  logic                   clk,
    input  hsl2rgb_pkg::frac_t     chan_hue,
    input  hsl2rgb_pkg::levels_t   levels,
    output hsl2rgb_pkg::frac_t     chan
);

    localparam int F      = hsl2rgb_pkg::FRAC_BITS;
    localparam int L      = hsl2rgb_pkg::LVL_W;
    localparam int PROD_W = L + F;

    // stage 1: segment and slope factor
    hsl2rgb_pkg::seg_t   seg_reg;
    hsl2rgb_pkg::seg_t   seg_next;
    hsl2rgb_pkg::frac_t  factor_reg;
    hsl2rgb_pkg::frac_t  factor_next;

    logic [F+2:0]        rise6;
    logic [F+2:0]        fall6;
    hsl2rgb_pkg::frac_t  fall_dist;

    // stage 2: span times factor
    hsl2rgb_pkg::seg_t   seg2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    hsl2rgb_pkg::lvl_t   m1_reg;
    hsl2rgb_pkg::lvl_t   m2_reg;

    // stage 3: select and saturate
    logic [L:0]          ramp_val;
    hsl2rgb_pkg::frac_t  chan_reg;
    hsl2rgb_pkg::frac_t  chan_next;

    always_comb
    begin
        fall_dist = hsl2rgb_pkg::TWO_THIRDS_Q - chan_hue;
        rise6     = {1'b0, chan_hue, 2'b00} + {2'b00, chan_hue, 1'b0};
        fall6     = {1'b0, fall_dist, 2'b00} + {2'b00, fall_dist, 1'b0};
        if (chan_hue < hsl2rgb_pkg::SIXTH_Q)
        begin
            seg_next    = hsl2rgb_pkg::SEG_RISE;
            factor_next = rise6[F-1:0];
        end
        else if (chan_hue < hsl2rgb_pkg::HALF_Q)
        begin
            seg_next    = hsl2rgb_pkg::SEG_HIGH;
            factor_next = '0;
        end
        else if (chan_hue < hsl2rgb_pkg::TWO_THIRDS_Q)
        begin
            seg_next    = hsl2rgb_pkg::SEG_FALL;
            factor_next = fall6[F-1:0];
        end
        else
        begin
            seg_next    = hsl2rgb_pkg::SEG_LOW;
            factor_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg    <= seg_next;
        factor_reg <= factor_next;
    end

    assign prod_next = PROD_W'(levels.span) * PROD_W'(factor_reg);

    always_ff @(posedge clk)
    begin
        seg2_reg <= seg_reg;
        prod_reg <= prod_next;
        m1_reg   <= levels.m1;
        m2_reg   <= levels.m2;
    end

    always_comb
    begin
        case (seg2_reg)
            hsl2rgb_pkg::SEG_RISE,
            hsl2rgb_pkg::SEG_FALL:
            begin
                ramp_val = {1'b0, m1_reg} + {1'b0, prod_reg[PROD_W-1:F]};
            end
            hsl2rgb_pkg::SEG_HIGH:
            begin
                ramp_val = {1'b0, m2_reg};
            end
            default:
            begin
                ramp_val = {1'b0, m1_reg};
            end
        endcase
        // clamp to the largest channel code
        if (ramp_val[L:F] != '0)
        begin
            chan_next = '1;
        end
        else
        begin
            chan_next = ramp_val[F-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

FILE: sv/hsl_to_rgb_converter_top.sv
// hsl_to_rgb_converter_top.sv: fully pipelined hsl to rgb pixel converter
// depends on hsl2rgb_pkg, hsl2rgb_levels, hsl2rgb_ramp and hsl_to_rgb_converter_top_defines.svh
//
// Converts one pixel per clock from hue, saturation and lightness (unsigned Q0.16) to
// saturated red, green and blue (unsigned Q0.16), with the alpha byte carried alongside.
// busy is always low, so a transaction is taken at every clock edge where start is high.
// Each pixel passes through all four register stages and leaves marked by a one-cycle done
// strobe; the four register stages are the lightness-saturation multiply, the m1/m2 level
// adders, the per-channel span multiply and the final level select and clamp. Results are
// not held: the receiver has to take red, green, blue and alpha_out in the cycle done is
// high, since there is no way to stall the output. Sustained rate is one pixel per cycle.

`include "hsl_to_rgb_converter_top_defines.svh"

module hsl_to_rgb_converter_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [hsl2rgb_pkg::FRAC_BITS-1:0]      hue,
    input  logic [hsl2rgb_pkg::FRAC_BITS-1:0]      saturation,
    input  logic [hsl2rgb_pkg::FRAC_BITS-1:0]      lightness,
    input  logic [hsl2rgb_pkg::ALPHA_W-1:0]        alpha_in,
    output logic                                   done,
    output logic [hsl2rgb_pkg::FRAC_BITS-1:0]      red,
    output logic [hsl2rgb_pkg::FRAC_BITS-1:0]      green,
    output logic [hsl2rgb_pkg::FRAC_BITS-1:0]      blue,
    output logic [hsl2rgb_pkg::ALPHA_W-1:0]        alpha_out
);

    localparam int DEPTH = hsl2rgb_pkg::PIPE_DEPTH;

    // one valid bit per stage; the last one is the done strobe
    logic [DEPTH-1:0]                  valid_reg;
    logic [DEPTH-1:0]                  valid_next;
    logic                              accept;

    // alpha rides along the pipeline, one register per stage
    logic [hsl2rgb_pkg::ALPHA_W-1:0]   alpha_pipe_reg [DEPTH];

    // channel hues, registered in stage 1
    hsl2rgb_pkg::frac_t                hue_r_reg;
    hsl2rgb_pkg::frac_t                hue_g_reg;
    hsl2rgb_pkg::frac_t                hue_b_reg;
    hsl2rgb_pkg::frac_t                hue_r_next;
    hsl2rgb_pkg::frac_t                hue_b_next;

    // ramp levels, valid in stage 2
    hsl2rgb_pkg::levels_t              levels;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign valid_next = {valid_reg[DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done = valid_reg[DEPTH-1];

    // red sits a third of a turn ahead of green, blue a third behind, both wrapping
    assign hue_r_next = hue + hsl2rgb_pkg::THIRD_Q;
    assign hue_b_next = hue - hsl2rgb_pkg::THIRD_Q;

    always_ff @(posedge clk)
    begin
        hue_r_reg <= hue_r_next;
        hue_g_reg <= hue;
        hue_b_reg <= hue_b_next;
    end

    always_ff @(posedge clk)
    begin
        alpha_pipe_reg[0] <= alpha_in;
        for (int i = 1; i < DEPTH; i++)
        begin
            alpha_pipe_reg[i] <= alpha_pipe_reg[i-1];
        end
    end

    assign alpha_out = alpha_pipe_reg[DEPTH-1];

    // stages 1 and 2: m1, m2 and span
    hsl2rgb_levels u_levels
    (
        .clk        (clk),
        .saturation (saturation),
        .lightness  (lightness),
        .levels     (levels)
    );

    // stages 2 to 4: one hue ramp per channel
    hsl2rgb_ramp u_ramp_red
    (
        .clk      (clk),
        .chan_hue (hue_r_reg),
        .levels   (levels),
        .chan     (red)
    );

    hsl2rgb_ramp u_ramp_green
    (
        .clk      (clk),
        .chan_hue (hue_g_reg),
        .levels   (levels),
        .chan     (green)
    );

    hsl2rgb_ramp u_ramp_blue
    (
        .clk      (clk),
        .chan_hue (hue_b_reg),
        .levels   (levels),
        .chan     (blue)
    );

    // every taken transaction comes out as a done strobe
    `HSL2RGB_ASSERT_IMPL(a_latency, accept, ##4 done, "taken pixel did not leave after four cycles")
    // no result strobe without an earlier transaction
    `HSL2RGB_ASSERT_IMPL(a_no_spurious, done, $past(accept, 4), "result strobe without a pixel")
    // zero saturation gives a gray equal to the lightness on all channels
    `HSL2RGB_ASSERT_IMPL(a_gray, done && $past(saturation == '0, 4), red == green && green == blue && blue == $past(lightness, 4), "gray pixel channels differ from lightness")

endmodule
